FILE: design/f32c_pkg.sv
package f32c_pkg;

  // Bytes per block between folds
  localparam int unsigned BlockLen = 360;

  localparam int unsigned LowW  = 18;
  localparam int unsigned HighW = 26;
  localparam int unsigned PosW  = 9;
  localparam int unsigned FoldW = 17;

  typedef logic [LowW-1:0]  low_sum_t;
  typedef logic [HighW-1:0] high_sum_t;
  typedef logic [PosW-1:0]  block_pos_t;
  typedef logic [FoldW-1:0] fold_t;

  localparam low_sum_t   LowInit  = LowW'(16'hFFFF);
  localparam high_sum_t  HighInit = HighW'(16'hFFFF);
  localparam block_pos_t LastPos  = PosW'(BlockLen - 1);

  // Fold of the low sum: low 16 bits plus bits above 16
  function automatic fold_t fold_low(input low_sum_t v);
    return {1'b0, v[15:0]} + {15'b0, v[17:16]};
  endfunction

  // Fold of the high sum
  function automatic fold_t fold_high(input high_sum_t v);
    return {1'b0, v[15:0]} + {7'b0, v[25:16]};
  endfunction

  // Fold of an already folded 17-bit sum
  function automatic fold_t fold_again(input fold_t v);
    return {1'b0, v[15:0]} + {16'b0, v[16]};
  endfunction

endpackage

FILE: design/fletcher32_byte_checksum.sv
// Byte-serial Fletcher-32 checksum.
// Input channel: one message byte per word (data_byte_i) with last_byte_i
// marking the final byte; a word is taken at a clock edge where in_valid_i
// is high and in_stall_o is low. One byte can be taken every cycle while in_stall_o stays low.
// Output channel: one 32-bit checksum word per message (high sum in the
// upper half), taken where out_valid_o is high and out_stall_i is low.
// The final byte's sums are folded into the fold stage register when that
// byte is taken; the final fold then goes into the output register, which
// drives out_valid_o.
// Throughput: one byte per cycle while in_stall_o is low, set by the accumulate loop.
// Reset (rst_ni low, asynchronous) sets both sums to 0xFFFF, clears the
// block position and drops all pending results.
// A stalled output holds its word; the fold stage behind it still accepts
// one more checksum, and in_stall_o rises only when that stage is full too.
module fletcher32_byte_checksum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           checksum_o
);
  import f32c_pkg::*;

  low_sum_t   low_q, low_d;
  high_sum_t  high_q, high_d;
  block_pos_t pos_q, pos_d;

  logic  fold_valid_q, fold_valid_d;
  fold_t fold_low_q, fold_high_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] checksum_q;

  logic      accept, out_adv, fold_adv, block_end;
  low_sum_t  low_acc;
  high_sum_t high_acc;
  fold_t     low_f, high_f, low_ff, high_ff;

  // Handshake
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign fold_adv   = fold_valid_q && out_adv;
  assign in_stall_o = fold_valid_q && !out_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // Accumulate and block fold
  always_comb begin
    low_acc   = low_q + {10'b0, data_byte_i};
    high_acc  = high_q + {8'b0, low_acc};
    block_end = (pos_q == LastPos);
    low_f     = fold_low(low_acc);
    high_f    = fold_high(high_acc);

    low_d  = low_q;
    high_d = high_q;
    pos_d  = pos_q;
    if (accept) begin
      if (last_byte_i) begin
        low_d  = LowInit;
        high_d = HighInit;
        pos_d  = '0;
      end else if (block_end) begin
        low_d  = {1'b0, low_f};
        high_d = {9'b0, high_f};
        pos_d  = '0;
      end else begin
        low_d  = low_acc;
        high_d = high_acc;
        pos_d  = pos_q + PosW'(1);
      end
    end
  end

  // Fold stage occupancy
  always_comb begin
    fold_valid_d = fold_valid_q && !fold_adv;
    if (accept && last_byte_i) begin
      fold_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q        <= LowInit;
      high_q       <= HighInit;
      pos_q        <= '0;
      fold_valid_q <= 1'b0;
    end else begin
      low_q        <= low_d;
      high_q       <= high_d;
      pos_q        <= pos_d;
      fold_valid_q <= fold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      fold_low_q  <= low_f;
      fold_high_q <= high_f;
    end
  end

  // Final fold and output register
  assign low_ff  = fold_again(fold_low_q);
  assign high_ff = fold_again(fold_high_q);
  assign out_valid_d = out_adv ? fold_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_adv) begin
      checksum_q <= {high_ff[15:0], 16'b0} | {15'b0, low_ff};
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

endmodule

FILE: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import f32c_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 400;

  // Running Fletcher-32 sums per message; queue of checksums still to come out
  class checksum_board;
    low_sum_t    low_acc;
    high_sum_t   high_acc;
    block_pos_t  pos_in_block;
    logic [31:0] expected_sums[$];
    int unsigned errors;
    int unsigned bytes_taken;
    int unsigned sums_checked;

    function new();
      errors       = 0;
      bytes_taken  = 0;
      sums_checked = 0;
      restart();
    endfunction

    function void restart();
      low_acc      = LowInit;
      high_acc     = HighInit;
      pos_in_block = '0;
    endfunction

    // Low 16 bits plus the bits above them
    function logic [31:0] fold_once(logic [31:0] v);
      return {16'b0, v[15:0]} + (v >> 16);
    endfunction

    // Accumulate one accepted byte; on the last byte queue the checksum
    function void take_byte(logic [7:0] b, logic l);
      logic [31:0] s1;
      logic [31:0] s2;
      bytes_taken++;
      low_acc      = low_acc + low_sum_t'(b);
      high_acc     = high_acc + high_sum_t'(low_acc);
      pos_in_block = pos_in_block + PosW'(1);
      if (32'(pos_in_block) >= BlockLen || l) begin
        low_acc      = low_sum_t'(fold_once(32'(low_acc)));
        high_acc     = high_sum_t'(fold_once(32'(high_acc)));
        pos_in_block = '0;
      end
      if (l) begin
        s1 = fold_once(32'(low_acc));
        s2 = fold_once(32'(high_acc));
        expected_sums.push_back((s2 << 16) | s1);
        restart();
      end
    endfunction

    // Compare one accepted output word with the oldest queued checksum
    function void match_checksum(logic [31:0] actual);
      logic [31:0] want;
      if (expected_sums.size() == 0) begin
        $error("checksum: expected none, actual %h", actual);
        errors++;
        return;
      end
      want = expected_sums.pop_front();
      sums_checked++;
      if (actual !== want) begin
        $error("checksum: expected %h, actual %h", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] checksum_o;

  checksum_board board = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req_id    = 0;
  int unsigned cycles         = 0;
  int unsigned messages_sent  = 0;

  fletcher32_byte_checksum i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .checksum_o  (checksum_o)
  );

  always #2 clk_i = ~clk_i;

  // Run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.match_checksum(checksum_o);
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  initial begin : receiver
    int unsigned seen_id;
    int unsigned hold_left;
    seen_id   = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req_id != seen_id) begin
        seen_id   = hold_req_id;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one word, with random gaps before it; returns at the falling edge
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    board.take_byte(b, l);
    @(negedge clk_i);
  endtask

  // Fill: 0 random (biased to extremes), 1 all 0xFF, 2 all zero
  task automatic send_message(input int unsigned len, input int unsigned fill);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        1: b = 8'hFF;
        2: b = 8'h00;
        default: begin
          case ($urandom_range(7))
            0: b = 8'hFF;
            1: b = 8'h00;
            default: b = 8'($urandom());
          endcase
        end
      endcase
      send_byte(b, i == len - 1);
    end
    messages_sent++;
  endtask

  // Random messages until the byte budget is spent
  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                              input int unsigned budget);
    int unsigned start;
    int unsigned len;
    int unsigned fill;
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    start = board.bytes_taken;
    while (board.bytes_taken - start < budget) begin
      if ($urandom_range(15) == 0) len = $urandom_range(BlockLen + 1, BlockLen - 1);
      else len = $urandom_range(24, 1);
      case ($urandom_range(7))
        0, 1: fill = 1;
        2:    fill = 2;
        default: fill = 0;
      endcase
      send_message(len, fill);
    end
  endtask

  initial begin : stimulus
    int unsigned drain;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: single-byte extremes, short runs of each extreme, mixed values
    send_message(1, 2);
    send_message(1, 1);
    send_message(4, 1);
    send_message(2, 2);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    messages_sent++;
    for (int i = 0; i < 5; i++) send_byte((i % 2) ? 8'h00 : 8'hFF, i == 4);
    messages_sent++;

    // Message ending exactly on a block boundary, with the largest sums
    send_message(BlockLen, 1);

    random_phase(0, 0, 300);
    random_phase(81, 0, 300);
    random_phase(0, 81, 300);
    random_phase(12, 12, 300);

    // Long receiver hold-off while short messages keep coming
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_req_id    <= hold_req_id + 1;
    for (int i = 0; i < 40; i++) send_message(1, 0);

    in_valid_i  <= 1'b0;
    last_byte_i <= 1'b0;

    // Drain, then watch the output for anything stray
    drain = 0;
    while (board.expected_sums.size() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (board.expected_sums.size() != 0) begin
      $error("checksum: %0d expected words never arrived", board.expected_sums.size());
      board.errors++;
    end

    $display("Run took %0d bytes in %0d messages and checked %0d checksums,",
             board.bytes_taken, messages_sent, board.sums_checked);
    $display("with block-boundary messages, idle/stall mixes and one long output hold-off.");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/f32c_pkg.sv
design/fletcher32_byte_checksum.sv
sim/testbench.sv
